/* design/pps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the parity partition sorter.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int VALUE_W     = 32;
    localparam int CFG_W       = 2;
    localparam int MAX_RESULTS = 32;

    localparam logic [CFG_W-1:0] SORT_ASC  = 2'd0;
    localparam logic [CFG_W-1:0] SORT_DESC = 2'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // input transfer this cycle
        logic grp_clear;  // start the sort phase at the even store
        logic take_cur;   // latch entry i, start the inner pass
        logic cmp_step;   // compare entry j with held value
        logic wr_i;       // write held value back to entry i
        logic next_grp;   // move on to the odd store
        logic emit_init;  // start emission at the first non-empty store
        logic capture;    // load the output register
        logic run_clear;  // end of run: clear counts and drop flag
    } t_cmd;

    typedef struct packed {
        logic need_sort;  // current store needs an exchange pass
        logic grp;        // current store, 1 for odd
        logic j_last;     // inner pass at its final entry
        logic i_last;     // outer pass at its final entry
        logic out_last;   // output register holds the final result
    } t_status;

endpackage
`default_nettype wire

/* design/pps_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* design/pps_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: partitioned store, counts, exchange-sort compare, output register.
// ----------------------------------------------------------------------------
module pps_dp import pps_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cmd                      i_cmd,
    output t_status                        o_status,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_sort_order_we,
    input  wire logic        [CFG_W-1:0]   i_sort_order,
    output logic signed      [VALUE_W-1:0] o_value_out,
    output logic                           o_odd_group,
    output logic                           o_last_result,
    output logic                           o_overflow
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RAM_DEPTH = 2 * (2 ** AW);

    logic [CW-1:0]      r_even_cnt, n_even_cnt;
    logic [CW-1:0]      r_odd_cnt, n_odd_cnt;
    logic               r_drop, n_drop;
    logic [CFG_W-1:0]   r_order;
    logic               r_grp, n_grp;
    logic [AW-1:0]      r_i, n_i;
    logic [AW-1:0]      r_j, n_j;
    logic [VALUE_W-1:0] r_cur, n_cur;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_odd;
    logic               r_out_last;
    logic               r_out_ovf;

    logic               ram_we;
    logic [AW:0]        ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW:0]        ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic [CW:0]        total;
    logic [CW-1:0]      grp_cnt;
    logic               swap;
    logic               emit_last;
    logic               store_ok;
    logic [AW-1:0]      load_idx;

    pps_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign total   = (CW+1)'(r_even_cnt) + (CW+1)'(r_odd_cnt);
    assign grp_cnt = r_grp ? r_odd_cnt : r_even_cnt;

    // signed exchange test against the value held for position i
    assign swap = (r_order == SORT_ASC)
                ? ($signed(r_cur) > $signed(ram_rdata))
                : ($signed(ram_rdata) > $signed(r_cur));

    assign emit_last = r_grp ? ((CW'(r_i) + CW'(1)) == r_odd_cnt)
                             : (((CW'(r_i) + CW'(1)) == r_even_cnt) &&
                                (r_odd_cnt == '0));

    assign load_idx = i_value[0] ? r_odd_cnt[AW-1:0] : r_even_cnt[AW-1:0];
    assign store_ok = (32'(total) < MAX_RESULTS) &&
                      (i_value[0] ? (32'(r_odd_cnt) < CAPACITY)
                                  : (32'(r_even_cnt) < CAPACITY));

    always_comb begin
        n_even_cnt = r_even_cnt;
        n_odd_cnt  = r_odd_cnt;
        n_drop     = r_drop;
        n_grp      = r_grp;
        n_i        = r_i;
        n_j        = r_j;
        n_cur      = r_cur;
        ram_we     = 1'b0;
        ram_waddr  = {r_grp, r_j};
        ram_wdata  = r_cur;
        ram_raddr  = {r_grp, r_i};

        if (i_cmd.load) begin
            ram_waddr = {i_value[0], load_idx};
            ram_wdata = i_value;
            if (store_ok) begin
                ram_we = 1'b1;
                if (i_value[0]) begin
                    n_odd_cnt = r_odd_cnt + CW'(1);
                end else begin
                    n_even_cnt = r_even_cnt + CW'(1);
                end
            end else begin
                n_drop = 1'b1;
            end
        end
        if (i_cmd.grp_clear) begin
            n_grp = 1'b0;
            n_i   = '0;
        end
        if (i_cmd.take_cur) begin
            n_cur     = ram_rdata;
            n_j       = r_i + AW'(1);
            ram_raddr = {r_grp, r_i + AW'(1)};
        end
        if (i_cmd.cmp_step) begin
            if (swap) begin
                ram_we = 1'b1;
                n_cur  = ram_rdata;
            end
            n_j       = r_j + AW'(1);
            ram_raddr = {r_grp, r_j + AW'(1)};
        end
        if (i_cmd.wr_i) begin
            ram_we    = 1'b1;
            ram_waddr = {r_grp, r_i};
            n_i       = r_i + AW'(1);
            ram_raddr = {r_grp, r_i + AW'(1)};
        end
        if (i_cmd.next_grp) begin
            n_grp = 1'b1;
            n_i   = '0;
        end
        if (i_cmd.emit_init) begin
            n_grp = (r_even_cnt == '0);
            n_i   = '0;
        end
        if (i_cmd.capture) begin
            if (!r_grp && ((CW'(r_i) + CW'(1)) == r_even_cnt)) begin
                n_grp = 1'b1;
                n_i   = '0;
            end else begin
                n_i = r_i + AW'(1);
            end
        end
        if (i_cmd.run_clear) begin
            n_even_cnt = '0;
            n_odd_cnt  = '0;
            n_drop     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even_cnt <= '0;
            r_odd_cnt  <= '0;
            r_drop     <= 1'b0;
            r_order    <= SORT_ASC;
            r_grp      <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
        end else begin
            r_even_cnt <= n_even_cnt;
            r_odd_cnt  <= n_odd_cnt;
            r_drop     <= n_drop;
            r_grp      <= n_grp;
            r_i        <= n_i;
            r_j        <= n_j;
            if (i_sort_order_we) begin
                r_order <= i_sort_order;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_cmd.capture) begin
            r_out_value <= ram_rdata;
            r_out_odd   <= r_grp;
            r_out_last  <= emit_last;
            r_out_ovf   <= r_drop;
        end
    end

    assign o_status.need_sort = ((r_order == SORT_ASC) || (r_order == SORT_DESC)) &&
                                (grp_cnt >= CW'(2));
    assign o_status.grp       = r_grp;
    assign o_status.j_last    = (CW'(r_j) + CW'(1)) == grp_cnt;
    assign o_status.i_last    = ((CW+1)'(r_i) + (CW+1)'(2)) >= {1'b0, grp_cnt};
    assign o_status.out_last  = r_out_last;

    assign o_value_out   = r_out_value;
    assign o_odd_group   = r_out_odd;
    assign o_last_result = r_out_last;
    assign o_overflow    = r_out_ovf;

endmodule
`default_nettype wire

/* design/pps_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pps_ctrl
// Controller: load, exchange-sort sequencing per store, result emission.
// ----------------------------------------------------------------------------
module pps_ctrl import pps_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_last_item,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_SORT_PREP = 3'd1;
    localparam logic [2:0] S_SORT_CUR  = 3'd2;
    localparam logic [2:0] S_SORT_CMP  = 3'd3;
    localparam logic [2:0] S_SORT_WR   = 3'd4;
    localparam logic [2:0] S_EMIT_RD   = 3'd5;
    localparam logic [2:0] S_EMIT_CAP  = 3'd6;
    localparam logic [2:0] S_EMIT_HOLD = 3'd7;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_item) begin
                        o_cmd.grp_clear = 1'b1;
                        n_state = S_SORT_PREP;
                    end
                end
            end
            S_SORT_PREP: begin
                if (i_status.need_sort) begin
                    n_state = S_SORT_CUR;
                end else if (!i_status.grp) begin
                    o_cmd.next_grp = 1'b1;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_EMIT_RD;
                end
            end
            S_SORT_CUR: begin
                o_cmd.take_cur = 1'b1;
                n_state = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                o_cmd.cmp_step = 1'b1;
                if (i_status.j_last) begin
                    n_state = S_SORT_WR;
                end
            end
            S_SORT_WR: begin
                o_cmd.wr_i = 1'b1;
                if (!i_status.i_last) begin
                    n_state = S_SORT_CUR;
                end else if (!i_status.grp) begin
                    o_cmd.next_grp = 1'b1;
                    n_state = S_SORT_PREP;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_CAP;
            end
            S_EMIT_CAP: begin
                o_cmd.capture = 1'b1;
                n_state = S_EMIT_HOLD;
            end
            S_EMIT_HOLD: begin
                if (!i_out_stall) begin
                    if (i_status.out_last) begin
                        o_cmd.run_clear = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = (r_state == S_EMIT_HOLD);

endmodule
`default_nettype wire

/* design/parity_partition_sorter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// parity_partition_sorter
// Splits a run of signed values into even and odd stores, sorts each, emits.
// ----------------------------------------------------------------------------
// Loading takes one value per cycle until the transfer marked last. Values go
// to the even or odd half of one shared RAM; a value that finds no room is
// dropped and every result of that run carries the overflow flag. After the
// last transfer, for the ascending and descending orders, each store is
// exchange-sorted through the one RAM; other order codes leave the stores in
// arrival order. Each result is then read, captured into the output register
// and held until it transfers, evens first, then odds. No new input is taken
// until the last result transfers.
// ----------------------------------------------------------------------------
module parity_partition_sorter import pps_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_sort_order_we,
    input  wire logic        [CFG_W-1:0]   i_sort_order,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_last_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed      [VALUE_W-1:0] o_value_out,
    output logic                           o_odd_group,
    output logic                           o_last_result,
    output logic                           o_overflow
);

    t_cmd    cmd;
    t_status status;

    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_item (i_last_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pps_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_value         (i_value),
        .i_sort_order_we (i_sort_order_we),
        .i_sort_order    (i_sort_order),
        .o_value_out     (o_value_out),
        .o_odd_group     (o_odd_group),
        .o_last_result   (o_last_result),
        .o_overflow      (o_overflow)
    );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams signed values into the parity partition sorter in runs that end on
// a transfer marked last. Results are checked in order, field by field, against
// a software copy of the even and odd stores or a directed row's own result, in most
// phases with random idle bursts on both sides; the sort order changes between runs.
// ----------------------------------------------------------------------------
module testbench import pps_pkg::*; ();

    localparam int STORE_DEPTH = 32;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 57;
    localparam logic [CFG_W-1:0] SORT_KEEP  = 2'd2;
    localparam logic [CFG_W-1:0] SORT_SPARE = 2'd3;
    localparam int DIR_ROWS = 25;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      odd;
        logic                      last;
        logic                      ovf;
    } t_result;

    typedef struct packed {
        logic                      load_order;
        logic [CFG_W-1:0]          order;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      typed;
        t_result                   want;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_sort_order_we = 1'b0;
    logic [CFG_W-1:0]          i_sort_order = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      i_last_item = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [VALUE_W-1:0] o_value_out;
    logic                      o_odd_group;
    logic                      o_last_result;
    logic                      o_overflow;

    // predictor state
    logic signed [VALUE_W-1:0] parity_store [2][STORE_DEPTH];
    int                        group_count [2] = '{0, 0};
    logic                      run_dropped = 1'b0;
    logic [CFG_W-1:0]          sort_sel = SORT_ASC;
    t_result                   expected_results [$];

    int   fail_count = 0;
    int   quiet_cycles = 0;
    int   out_hold = 0;
    logic idling = 1'b0;

    const t_stim_row directed_rows [DIR_ROWS] = '{
        // single-value runs at the extremes, result read off directly
        '{1'b1, SORT_ASC, 32'sh7fffffff, 1'b1, 1'b1, '{32'sh7fffffff, 1'b1, 1'b1, 1'b0}},
        '{1'b0, SORT_ASC, 32'sh80000000, 1'b1, 1'b1, '{32'sh80000000, 1'b0, 1'b1, 1'b0}},
        '{1'b0, SORT_ASC, 32'sh00000000, 1'b1, 1'b1, '{32'sh00000000, 1'b0, 1'b1, 1'b0}},
        '{1'b0, SORT_ASC, 32'shffffffff, 1'b1, 1'b1, '{32'shffffffff, 1'b1, 1'b1, 1'b0}},
        // mixed run with ties, ascending
        '{1'b0, SORT_ASC, 32'sd5,          1'b0, 1'b0, '0},
        '{1'b0, SORT_ASC, -32'sd3,         1'b0, 1'b0, '0},
        '{1'b0, SORT_ASC, 32'sd8,          1'b0, 1'b0, '0},
        '{1'b0, SORT_ASC, 32'sh80000000,   1'b0, 1'b0, '0},
        '{1'b0, SORT_ASC, 32'sh7fffffff,   1'b0, 1'b0, '0},
        '{1'b0, SORT_ASC, 32'sd8,          1'b0, 1'b0, '0},
        '{1'b0, SORT_ASC, 32'sd5,          1'b0, 1'b0, '0},
        '{1'b0, SORT_ASC, -32'sd4,         1'b1, 1'b0, '0},
        // same run, descending
        '{1'b1, SORT_DESC, 32'sd5,         1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, -32'sd3,        1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, 32'sd8,         1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, 32'sh80000000,  1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, 32'sh7fffffff,  1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, 32'sd8,         1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, 32'sd5,         1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, -32'sd4,        1'b1, 1'b0, '0},
        // even values only, then odd values only
        '{1'b0, SORT_DESC, 32'sd6,         1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, 32'sd2,         1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, 32'sd4,         1'b1, 1'b0, '0},
        '{1'b0, SORT_DESC, 32'sd3,         1'b0, 1'b0, '0},
        '{1'b0, SORT_DESC, 32'sd1,         1'b1, 1'b0, '0}
    };

    const logic [CFG_W-1:0] phase_order [PHASES] =
        '{SORT_ASC, SORT_DESC, SORT_KEEP, SORT_SPARE, SORT_DESC, SORT_ASC};
    const logic phase_idle [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    parity_partition_sorter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sort_order_we (i_sort_order_we),
        .i_sort_order    (i_sort_order),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_value         (i_value),
        .i_last_item     (i_last_item),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_value_out     (o_value_out),
        .o_odd_group     (o_odd_group),
        .o_last_result   (o_last_result),
        .o_overflow      (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // store by parity; on the last value sort both groups if ordered and queue results
    task automatic partition_value(input logic signed [VALUE_W-1:0] v, input logic last,
                                   input logic typed, input t_result want);
        int g;
        int total;
        int n;
        logic signed [VALUE_W-1:0] held;
        logic swap;
        t_result res;
        g = int'(v[0]);
        if (group_count[0] + group_count[1] >= MAX_RESULTS
                || group_count[g] >= STORE_DEPTH) begin
            run_dropped = 1'b1;
        end else begin
            parity_store[g][group_count[g]] = v;
            group_count[g]++;
        end
        if (!last) return;
        for (int s = 0; s < 2; s++) begin
            if (sort_sel == SORT_ASC || sort_sel == SORT_DESC) begin
                for (int i = 0; i < group_count[s]; i++) begin
                    for (int j = i + 1; j < group_count[s]; j++) begin
                        swap = (sort_sel == SORT_ASC) ? parity_store[s][i] > parity_store[s][j]
                                                      : parity_store[s][j] > parity_store[s][i];
                        if (swap) begin
                            held = parity_store[s][i];
                            parity_store[s][i] = parity_store[s][j];
                            parity_store[s][j] = held;
                        end
                    end
                end
            end
        end
        if (typed) begin
            expected_results.push_back(want);
        end else begin
            total = group_count[0] + group_count[1];
            n = 0;
            for (int s = 0; s < 2; s++) begin
                for (int i = 0; i < group_count[s]; i++) begin
                    n++;
                    res.value = parity_store[s][i];
                    res.odd   = s[0];
                    res.last  = (n == total);
                    res.ovf   = run_dropped;
                    expected_results.push_back(res);
                end
            end
        end
        group_count = '{0, 0};
        run_dropped = 1'b0;
    endtask

    task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic last,
                             input logic typed, input t_result want);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_value     <= v;
        i_last_item <= last;
        do @(posedge i_clk); while (o_in_stall);
        partition_value(v, last, typed, want);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [CFG_W-1:0] sel);
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_sort_order_we <= 1'b1;
        i_sort_order    <= sel;
        @(posedge i_clk);
        i_sort_order_we <= 1'b0;
        sort_sel = sel;
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 15)) - 32'd8;  // small range for ties
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sh00000000;
                    default: return 32'shffffffff;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic flag_result(input string why, input t_result want, input t_result got);
        fail_count++;
        if (fail_count <= 10)
            $display({"%s: expected value %0d odd %0b last %0b ovf %0b, ",
                      "got value %0d odd %0b last %0b ovf %0b"},
                     why, want.value, want.odd, want.last, want.ovf,
                     got.value, got.odd, got.last, got.ovf);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_value_out, o_odd_group, o_last_result, o_overflow};
            if (expected_results.size() == 0) begin
                flag_result("unexpected result", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.value !== want.value || got.odd !== want.odd
                        || got.last !== want.last || got.ovf !== want.ovf)
                    flag_result("result mismatch", want, got);
            end
        end
    end

    // output stall in random bursts while idling
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold    <= out_hold - 1;
            i_out_stall <= (out_hold > 1);
        end else if (idling && $urandom_range(0, 3) == 0) begin
            out_hold    <= $urandom_range(1, 13);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int sent;
        int run_len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idling = 1'b1;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (directed_rows[r].load_order)
                write_order(directed_rows[r].order);
            send_item(directed_rows[r].value, directed_rows[r].last,
                      directed_rows[r].typed, directed_rows[r].want);
        end

        // mostly short runs, now and then one long enough to overflow the stores
        for (int p = 0; p < PHASES; p++) begin
            write_order(phase_order[p]);
            idling = phase_idle[p];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 38)
                                                      : $urandom_range(1, 10);
                for (int k = 0; k < run_len; k++)
                    send_item(pick_value(), k == run_len - 1, 1'b0, '0);
                sent += run_len;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
